### design/ptc_pkg.sv
// Shared types and constants of the pressure and temperature compensation block.
`default_nettype none

package ptc_pkg;

  // input word: raw sensor frames
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [19:0] temperature_centi;
    logic               temperature_ok;
    logic [31:0]        pressure_q24_8;
    logic               pressure_ok;
  } out_word_t;

  // calibration registers as held in the top level
  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [15:0] p9;
  } coeff_t;

  // register indexes on the configuration port
  localparam logic [1:0] RegTempCoeffs = 2'd0;
  localparam logic [1:0] RegPressA     = 2'd1;
  localparam logic [1:0] RegPressB     = 2'd2;
  localparam logic [1:0] RegPressP9    = 2'd3;

  // number of quotient bits, one divider cell per bit
  localparam int unsigned DivBits = 64;

  localparam int TfineOffset = 128000;
  localparam int PressBase   = 1048576;
  localparam int PressScale  = 3125;
  localparam int TempRound   = 128;
  localparam int TempLow     = -8000;
  localparam int TempHigh    = 10000;

  // word that rides along the divider chain
  typedef struct packed {
    logic               neg;
    logic               pok;
    logic signed [19:0] tc;
    logic               tok;
  } side_t;

  // word handed from one divider cell to the next
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;
    logic [63:0] ub;
    side_t       side;
  } div_word_t;

endpackage

`default_nettype wire

### design/ptc_div_cell.sv
// One restoring division cell: resolves one quotient bit per word.
`default_nettype none

module ptc_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  ptc_pkg::div_word_t    word_i,
  output logic                  vld_o,
  output ptc_pkg::div_word_t    word_o
);

  logic [64:0] trial;
  logic [64:0] diff;
  logic        take;
  logic        vld_q;
  ptc_pkg::div_word_t word_q;

  assign trial = {word_i.rem, word_i.nq[63]};
  assign diff  = trial - {1'b0, word_i.ub};
  assign take  = ~diff[64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q.rem  <= take ? diff[63:0] : trial[63:0];
    word_q.nq   <= {word_i.nq[62:0], take};
    word_q.ub   <= word_i.ub;
    word_q.side <= word_i.side;
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

`default_nettype wire

### design/ptc_front.sv
// Front pipeline: fine temperature, temperature result, pressure dividend and divisor.
`default_nettype none

module ptc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  ptc_pkg::in_word_t  in_word_i,
  input  ptc_pkg::coeff_t    coeff_i,
  output logic               vld_o,
  output ptc_pkg::div_word_t div_o
);

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
  logic [19:0]        adc_t;

  assign t1 = coeff_i.temp[15:0];
  assign t2 = $signed(coeff_i.temp[31:16]);
  assign t3 = $signed(coeff_i.temp[47:32]);
  assign p1 = coeff_i.press_a[15:0];
  assign p2 = $signed(coeff_i.press_a[31:16]);
  assign p3 = $signed(coeff_i.press_a[47:32]);
  assign p4 = $signed(coeff_i.press_a[63:48]);
  assign p5 = $signed(coeff_i.press_b[15:0]);
  assign p6 = $signed(coeff_i.press_b[31:16]);
  assign adc_t = in_word_i.raw_temperature[23:4];

  logic [10:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[9:0], vld_i};
    end
  end

  // stage 1: temperature differences and first products
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] m1_d, sq_d, m1_q, sq_q;
  assign d1   = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2   = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, t1});
  assign m1_d = d1 * t2;
  assign sq_d = d2 * d2;

  // stage 2
  logic signed [21:0] sqs;
  logic signed [37:0] m2_d, m2_q;
  logic signed [22:0] at_q;
  assign sqs  = sq_q[33:12];
  assign m2_d = sqs * t3;

  // stage 3: fine temperature
  logic signed [24:0] tf_d, tf_q;
  assign tf_d = $signed({{2{at_q[22]}}, at_q}) + $signed({m2_q[37], m2_q[37:14]});

  // stage 4: centidegrees and pressure offset
  logic signed [28:0] tr;
  logic signed [20:0] tcw;
  logic signed [19:0] tc_d;
  logic               tok_d;
  logic signed [25:0] pa_d, pa_q;
  assign tr  = $signed({{2{tf_q[24]}}, tf_q, 2'b00}) + $signed({{4{tf_q[24]}}, tf_q})
             + 29'(ptc_pkg::TempRound);
  assign tcw = tr[28:8];
  assign tok_d = (tcw >= 21'(ptc_pkg::TempLow)) && (tcw <= 21'(ptc_pkg::TempHigh));
  // clamp to the 20-bit field
  assign tc_d = (tcw[20] != tcw[19]) ? (tcw[20] ? {1'b1, 19'd0} : {1'b0, {19{1'b1}}})
                                     : tcw[19:0];
  assign pa_d = $signed({tf_q[24], tf_q}) - 26'(ptc_pkg::TfineOffset);

  // stage 5
  logic signed [51:0] aa_d, aa_q;
  logic signed [41:0] ap5_d, ap2_d, ap5_q, ap2_q, ap5_6q, ap2_6q;
  assign aa_d  = pa_q * pa_q;
  assign ap5_d = pa_q * p5;
  assign ap2_d = pa_q * p2;

  // stage 6
  logic signed [67:0] b6_full, b3_full;
  logic [63:0]        b6_q, b3_q;
  assign b6_full = aa_q * p6;
  assign b3_full = aa_q * p3;

  // stage 7: wrap-around 64-bit sums
  logic [63:0] b_d, aq_d, b_q, aq_q;
  assign b_d  = b6_q + ({{22{ap5_6q[41]}}, ap5_6q} << 17) + ({{48{p4[15]}}, p4} << 35);
  assign aq_d = {{8{b3_q[63]}}, b3_q[63:8]} + ({{22{ap2_6q[41]}}, ap2_6q} << 12);

  // stage 8: divisor partial products and dividend base
  logic [19:0] adcp_q [7];
  logic [63:0] x8;
  logic [47:0] lo8_d, hi8_full, lo8_q;
  logic [31:0] hi8_q;
  logic [20:0] pn;
  logic [63:0] num0_d, num0_q;
  assign x8       = aq_q + 64'h0000_8000_0000_0000;
  assign lo8_d    = x8[31:0] * p1;
  assign hi8_full = x8[63:32] * p1;
  assign pn       = 21'(ptc_pkg::PressBase) - {1'b0, adcp_q[6]};
  assign num0_d   = {12'd0, pn, 31'd0} - b_q;

  // stage 9
  logic [63:0] prod9, dv_d, dv_q, dv10_q;
  logic [43:0] lo9_d, hi9_full, lo9_q;
  logic [31:0] hi9_q;
  assign prod9    = {hi8_q, 32'd0} + {16'd0, lo8_q};
  assign dv_d     = {{33{prod9[63]}}, prod9[63:33]};
  assign lo9_d    = num0_q[31:0] * 12'(ptc_pkg::PressScale);
  assign hi9_full = num0_q[63:32] * 12'(ptc_pkg::PressScale);

  // stage 10: dividend
  logic [63:0] num_d, num_q;
  assign num_d = {hi9_q, 32'd0} + {20'd0, lo9_q};

  // stage 11: magnitudes for the unsigned divider
  logic signed [19:0] tc_q  [7];
  logic               tok_q [7];
  ptc_pkg::div_word_t div_d, div_q;
  always_comb begin
    div_d.rem       = '0;
    div_d.nq        = num_q[63] ? (64'd0 - num_q) : num_q;
    div_d.ub        = dv10_q[63] ? (64'd0 - dv10_q) : dv10_q;
    div_d.side.neg  = num_q[63] ^ dv10_q[63];
    div_d.side.pok  = |dv10_q;
    div_d.side.tc   = tc_q[6];
    div_d.side.tok  = tok_q[6];
  end

  always_ff @(posedge clk_i) begin
    m1_q      <= m1_d;
    sq_q      <= sq_d;
    adcp_q[0] <= in_word_i.raw_pressure[23:4];
    for (int i = 1; i < 7; i++) begin
      adcp_q[i] <= adcp_q[i-1];
    end
    at_q      <= m1_q[33:11];
    m2_q      <= m2_d;
    tf_q      <= tf_d;
    tc_q[0]   <= tc_d;
    tok_q[0]  <= tok_d;
    for (int i = 1; i < 7; i++) begin
      tc_q[i]  <= tc_q[i-1];
      tok_q[i] <= tok_q[i-1];
    end
    pa_q      <= pa_d;
    aa_q      <= aa_d;
    ap5_q     <= ap5_d;
    ap2_q     <= ap2_d;
    b6_q      <= b6_full[63:0];
    b3_q      <= b3_full[63:0];
    ap5_6q    <= ap5_q;
    ap2_6q    <= ap2_q;
    b_q       <= b_d;
    aq_q      <= aq_d;
    lo8_q     <= lo8_d;
    hi8_q     <= hi8_full[31:0];
    num0_q    <= num0_d;
    dv_q      <= dv_d;
    lo9_q     <= lo9_d;
    hi9_q     <= hi9_full[31:0];
    num_q     <= num_d;
    dv10_q    <= dv_q;
    div_q     <= div_d;
  end

  assign vld_o = vld_q[10];
  assign div_o = div_q;

endmodule

`default_nettype wire

### design/ptc_back.sv
// Back pipeline: signed quotient, second-order pressure terms, clamping.
`default_nettype none

module ptc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [63:0]        uq_i,
  input  ptc_pkg::side_t     side_i,
  input  ptc_pkg::coeff_t    coeff_i,
  output logic               vld_o,
  output ptc_pkg::out_word_t res_o
);

  logic signed [15:0] p7, p8, p9;
  assign p7 = $signed(coeff_i.press_b[47:32]);
  assign p8 = $signed(coeff_i.press_b[63:48]);
  assign p9 = $signed(coeff_i.p9);

  logic [6:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  ptc_pkg::side_t sd_q [6];
  logic [63:0]    q_q  [5];

  // stage 1: square of p/2^13 and p*P8, split in 32-bit halves
  logic [63:0]        xs;
  logic [63:0]        xlxl_d, xlxl_q;
  logic [31:0]        xhxl_d, xhxl_q;
  logic signed [48:0] w2lo_d, w2lo_q;
  logic [31:0]        w2hi_d, w2hi_q;
  assign xs     = {{13{q_q[0][63]}}, q_q[0][63:13]};
  assign xlxl_d = xs[31:0] * xs[31:0];
  assign xhxl_d = xs[63:32] * xs[31:0];
  assign w2lo_d = $signed({1'b0, q_q[0][31:0]}) * p8;
  assign w2hi_d = q_q[0][63:32] * {{16{p8[15]}}, p8};

  // stage 2
  logic [63:0] sq_d, sq_q, w2_d, w2_q;
  assign sq_d = xlxl_q + {xhxl_q[30:0], 33'd0};
  assign w2_d = {{15{w2lo_q[48]}}, w2lo_q} + {w2hi_q, 32'd0};

  // stage 3: times P9
  logic signed [48:0] s9lo_d, s9lo_q;
  logic [31:0]        s9hi_d, s9hi_q;
  logic [63:0]        w2s_q, w2s4_q;
  assign s9lo_d = $signed({1'b0, sq_q[31:0]}) * p9;
  assign s9hi_d = sq_q[63:32] * {{16{p9[15]}}, p9};

  // stage 4
  logic [63:0] w1full, w1_q;
  assign w1full = {{15{s9lo_q[48]}}, s9lo_q} + {s9hi_q, 32'd0};

  // stage 5
  logic [63:0] sum_q;

  // stage 6: final offset and clamp
  logic [63:0]        pw;
  ptc_pkg::out_word_t res_d, res_q;
  assign pw = {{8{sum_q[63]}}, sum_q[63:8]} + ({{48{p7[15]}}, p7} << 4);
  always_comb begin
    res_d.temperature_centi = sd_q[5].tc;
    res_d.temperature_ok    = sd_q[5].tok;
    res_d.pressure_ok       = sd_q[5].pok;
    if (!sd_q[5].pok || pw[63]) begin
      res_d.pressure_q24_8 = '0;
    end else if (|pw[62:32]) begin
      res_d.pressure_q24_8 = '1;
    end else begin
      res_d.pressure_q24_8 = pw[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    q_q[0]  <= side_i.neg ? (64'd0 - uq_i) : uq_i;
    sd_q[0] <= side_i;
    for (int i = 1; i < 6; i++) begin
      sd_q[i] <= sd_q[i-1];
    end
    for (int i = 1; i < 5; i++) begin
      q_q[i] <= q_q[i-1];
    end
    xlxl_q <= xlxl_d;
    xhxl_q <= xhxl_d;
    w2lo_q <= w2lo_d;
    w2hi_q <= w2hi_d;
    sq_q   <= sq_d;
    w2_q   <= w2_d;
    s9lo_q <= s9lo_d;
    s9hi_q <= s9hi_d;
    w2s_q  <= {{19{w2_q[63]}}, w2_q[63:19]};
    w2s4_q <= w2s_q;
    w1_q   <= {{25{w1full[63]}}, w1full[63:25]};
    sum_q  <= q_q[4] + w1_q + w2s4_q;
    res_q  <= res_d;
  end

  assign vld_o = vld_q[6];
  assign res_o = res_q;

endmodule

`default_nettype wire

### design/pressure_temperature_compensation_top.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// Pipeline: a result word is strobed on done_o once its start word has passed
//   11 front stages, 64 divider cells and 7 back stages.
// Throughput: one word per cycle; busy stays low, and the 64-cell divider chain
//   sets the depth. The receiver cannot stall, so no result is ever held.
// Reset: asynchronous, active low; clears all valid flags and the calibration
//   registers to zero. No clearing pass is needed.
`default_nettype none

module pressure_temperature_compensation_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ptc_pkg::in_word_t  in_word_i,
  output logic               done_o,
  output ptc_pkg::out_word_t res_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int unsigned Latency = 82;

  // Every cycle takes a word: the pipeline never pushes back.
  assign busy = 1'b0;

  // Calibration registers; the user must write them only while the pipeline is empty, the block does not enforce this.
  ptc_pkg::coeff_t coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptc_pkg::RegTempCoeffs: coeff_q.temp    <= cfg_data_i[47:0];
        ptc_pkg::RegPressA:     coeff_q.press_a <= cfg_data_i;
        ptc_pkg::RegPressB:     coeff_q.press_b <= cfg_data_i;
        ptc_pkg::RegPressP9:    coeff_q.p9      <= cfg_data_i[15:0];
        default:                coeff_q         <= coeff_q;
      endcase
    end
  end

  // Front: fine temperature, centidegrees, then dividend and divisor magnitudes.
  logic               cell_vld  [ptc_pkg::DivBits+1];
  ptc_pkg::div_word_t cell_word [ptc_pkg::DivBits+1];

  ptc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (start & ~busy),
    .in_word_i (in_word_i),
    .coeff_i   (coeff_q),
    .vld_o     (cell_vld[0]),
    .div_o     (cell_word[0])
  );

  // Divider chain: each cell resolves one quotient bit, MSB first, and
  // hands remainder, shifted dividend/quotient and sideband to its neighbor.
  for (genvar gi = 0; gi < ptc_pkg::DivBits; gi++) begin : g_cell
    ptc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (cell_vld[gi]),
      .word_i (cell_word[gi]),
      .vld_o  (cell_vld[gi+1]),
      .word_o (cell_word[gi+1])
    );
  end

  // Back: restore quotient sign, add second-order terms, clamp to Q24.8.
  ptc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (cell_vld[ptc_pkg::DivBits]),
    .uq_i    (cell_word[ptc_pkg::DivBits].nq),
    .side_i  (cell_word[ptc_pkg::DivBits].side),
    .coeff_i (coeff_q),
    .vld_o   (done_o),
    .res_o   (res_o)
  );

  // A strobe only follows an accepted word; the check looks back by the Latency parameter.
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start & ~busy, Latency))
    else $error("result strobe without matching start");

  // Zero divisor forces a zero pressure word.
  a_zero_div_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.pressure_ok) |-> (res_o.pressure_q24_8 == '0))
    else $error("pressure not cleared on zero divisor");

  // Temperature flag matches the reported value window.
  a_temp_ok_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.temperature_ok) |->
      ((res_o.temperature_centi >= 20'sd0 - 20'sd8000) &&
       (res_o.temperature_centi <= 20'sd10000)))
    else $error("temperature flagged ok outside window");

endmodule

`default_nettype wire
